[rtl/sks_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sks_pkg: shared definitions for the sorted key set
// Field widths, operation codes and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sks_pkg;

   localparam int CAPACITY_DEF = 256;
   localparam int KEY_W        = 64;
   localparam int MODE_W       = 2;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TEST   = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture request, start walk at list head
      logic advance;     // step to the next entry
      logic settle;      // walk ends: latch hit flag and successor link
      logic free_read;   // read link of free-list head
      logic free_take;   // pop free-list head as the new entry
      logic fill_take;   // take next never-used entry
      logic ins_node;    // write key and link of the new entry
      logic ins_prev;    // hook new entry behind its predecessor
      logic rem_prev;    // bypass the removed entry
      logic rem_node;    // push removed entry on the free list
      logic rsp_load;    // load the output word
      logic rsp_success;
      logic rsp_full;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic              advance;     // current entry lies below the key
      logic              found;       // latched at end of walk
      logic              free_avail;  // free list not empty
      logic              fill_avail;  // unused entries remain
      logic              rsp_free;    // output register can take a word
      logic [MODE_W-1:0] mode;
   } status_type;

endpackage

[rtl/sks_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sks_ram: simple dual-port RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module sks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sks_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sks_dpath: sorted key set datapath
// Key and link memories, walk pointers, list/free-list heads, output word.
// ----------------------------------------------------------------------------
module sks_dpath #(
   parameter int CAPACITY = sks_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sks_pkg::cmd_type                  cmd,
   output sks_pkg::status_type               status,
   input  logic [sks_pkg::MODE_W-1:0]        req_mode,
   input  logic signed [sks_pkg::KEY_W-1:0]  req_key,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_success,
   output logic                              rsp_full_error
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int PTR_W = $clog2(CAPACITY + 1);
   localparam logic [PTR_W-1:0] END_PTR = PTR_W'(CAPACITY);

   logic [sks_pkg::MODE_W-1:0]       mode_ff, mode_in;
   logic signed [sks_pkg::KEY_W-1:0] key_ff, key_in;
   logic [PTR_W-1:0] cur_ff, cur_in;
   logic [PTR_W-1:0] prev_ff, prev_in;
   logic [PTR_W-1:0] steps_ff, steps_in;
   logic [PTR_W-1:0] next_ff, next_in;
   logic [PTR_W-1:0] node_ff, node_in;
   logic [PTR_W-1:0] first_ff, first_in;
   logic [PTR_W-1:0] free_ff, free_in;
   logic [PTR_W-1:0] fill_ff, fill_in;
   logic             found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_success_ff, rsp_success_in;
   logic             rsp_full_ff, rsp_full_in;

   logic [IDX_W-1:0]         rd_addr;
   logic [sks_pkg::KEY_W-1:0] key_rd;
   logic [PTR_W-1:0]         link_rd;
   logic                     key_we;
   logic                     link_we;
   logic [IDX_W-1:0]         link_wa;
   logic [PTR_W-1:0]         link_wd;
   logic                     cur_live;
   logic                     prev_live;

   assign cur_live  = (cur_ff < END_PTR);
   assign prev_live = (prev_ff < END_PTR);

   // read port follows the walk; data of cur_ff is valid while walking
   always_comb begin
      if (cmd.load) begin
         rd_addr = first_ff[IDX_W-1:0];
      end else if (cmd.advance) begin
         rd_addr = link_rd[IDX_W-1:0];
      end else if (cmd.free_read) begin
         rd_addr = free_ff[IDX_W-1:0];
      end else begin
         rd_addr = cur_ff[IDX_W-1:0];
      end
   end

   assign key_we = cmd.ins_node;

   always_comb begin
      link_we = 1'b0;
      link_wa = cur_ff[IDX_W-1:0];
      link_wd = free_ff;
      if (cmd.ins_node) begin
         link_we = 1'b1;
         link_wa = node_ff[IDX_W-1:0];
         link_wd = cur_ff;
      end else if (cmd.ins_prev) begin
         link_we = prev_live;
         link_wa = prev_ff[IDX_W-1:0];
         link_wd = node_ff;
      end else if (cmd.rem_prev) begin
         link_we = prev_live;
         link_wa = prev_ff[IDX_W-1:0];
         link_wd = next_ff;
      end else if (cmd.rem_node) begin
         link_we = 1'b1;
      end
   end

   sks_ram #(
      .WIDTH (sks_pkg::KEY_W),
      .DEPTH (CAPACITY)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (node_ff[IDX_W-1:0]),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   sks_ram #(
      .WIDTH (PTR_W),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_addr (rd_addr),
      .rd_data (link_rd)
   );

   always_comb begin
      mode_in        = mode_ff;
      key_in         = key_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      steps_in       = steps_ff;
      next_in        = next_ff;
      node_in        = node_ff;
      first_in       = first_ff;
      free_in        = free_ff;
      fill_in        = fill_ff;
      found_in       = found_ff;
      rsp_success_in = rsp_success_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         mode_in  = req_mode;
         key_in   = req_key;
         cur_in   = first_ff;
         prev_in  = END_PTR;
         steps_in = '0;
      end
      if (cmd.advance) begin
         prev_in  = cur_ff;
         cur_in   = link_rd;
         steps_in = steps_ff + PTR_W'(1);
      end
      if (cmd.settle) begin
         found_in = cur_live && ($signed(key_rd) == key_ff);
         next_in  = link_rd;
      end
      if (cmd.free_take) begin
         node_in = free_ff;
         free_in = link_rd;
      end
      if (cmd.fill_take) begin
         node_in = fill_ff;
         fill_in = fill_ff + PTR_W'(1);
      end
      if (cmd.ins_prev && !prev_live) begin
         first_in = node_ff;
      end
      if (cmd.rem_prev && !prev_live) begin
         first_in = next_ff;
      end
      if (cmd.rem_node) begin
         free_in = cur_ff;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_success_in = cmd.rsp_success;
         rsp_full_in    = cmd.rsp_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= END_PTR;
         free_ff      <= END_PTR;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         first_ff     <= first_in;
         free_ff      <= free_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      key_ff         <= key_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      steps_ff       <= steps_in;
      next_ff        <= next_in;
      node_ff        <= node_in;
      found_ff       <= found_in;
      rsp_success_ff <= rsp_success_in;
      rsp_full_ff    <= rsp_full_in;
   end

   assign status.advance    = cur_live && (steps_ff < END_PTR) && ($signed(key_rd) < key_ff);
   assign status.found      = found_ff;
   assign status.free_avail = (free_ff < END_PTR);
   assign status.fill_avail = (fill_ff < END_PTR);
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign status.mode       = mode_ff;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_success    = rsp_success_ff;
   assign rsp_full_error = rsp_full_ff;

endmodule

[rtl/sks_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sks_ctrl: sorted key set controller
// Sequences walk, allocation, relinking and result hand-off.
// ----------------------------------------------------------------------------
module sks_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sks_pkg::status_type status,
   output sks_pkg::cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_WALK     = 9'b000000010,
      S_DECIDE   = 9'b000000100,
      S_FREE_GET = 9'b000001000,
      S_INS_NODE = 9'b000010000,
      S_INS_PREV = 9'b000100000,
      S_REM_PREV = 9'b001000000,
      S_REM_NODE = 9'b010000000,
      S_DONE     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      succ_ff, succ_in;
   logic      full_ff, full_in;

   always_comb begin
      state_in = state_ff;
      succ_in  = succ_ff;
      full_in  = full_ff;
      cmd      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               succ_in  = 1'b0;
               full_in  = 1'b0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (status.advance) begin
               cmd.advance = 1'b1;
            end else begin
               cmd.settle = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_DONE;
            case (status.mode)
               sks_pkg::MODE_TEST: begin
                  succ_in = status.found;
               end
               sks_pkg::MODE_INSERT: begin
                  if (!status.found) begin
                     if (status.free_avail) begin
                        cmd.free_read = 1'b1;
                        state_in      = S_FREE_GET;
                     end else if (status.fill_avail) begin
                        cmd.fill_take = 1'b1;
                        state_in      = S_INS_NODE;
                     end else begin
                        full_in = 1'b1;
                     end
                  end
               end
               sks_pkg::MODE_REMOVE: begin
                  if (status.found) begin
                     state_in = S_REM_PREV;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_FREE_GET: begin
            cmd.free_take = 1'b1;
            state_in      = S_INS_NODE;
         end
         S_INS_NODE: begin
            cmd.ins_node = 1'b1;
            state_in     = S_INS_PREV;
         end
         S_INS_PREV: begin
            cmd.ins_prev = 1'b1;
            succ_in      = 1'b1;
            state_in     = S_DONE;
         end
         S_REM_PREV: begin
            cmd.rem_prev = 1'b1;
            state_in     = S_REM_NODE;
         end
         S_REM_NODE: begin
            cmd.rem_node = 1'b1;
            succ_in      = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load    = 1'b1;
               cmd.rsp_success = succ_ff;
               cmd.rsp_full    = full_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         succ_ff  <= 1'b0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         succ_ff  <= succ_in;
         full_ff  <= full_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

[rtl/sorted_key_set.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_set: ordered set of signed 64-bit keys
// Singly linked ascending list in a bounded entry store, with a free list.
// ----------------------------------------------------------------------------
// Each request word carries an operation (insert, remove, test) and a signed
// key; exactly one response word follows, in order. The block handles one
// request at a time. After acceptance it walks the list from the head, one
// entry per cycle, until it reaches the first entry not below the key; the
// walk is paced by the registered read of the key/link memories, whose
// output feeds the next read address. A test, a miss and a refused insert
// go from the decision straight to the response; a remove bypasses the
// entry at its predecessor, then frees it; an insert writes the new entry
// (after a free-list pop, which costs one extra link read), then hooks it
// behind its predecessor. The next word is taken back in idle. A finished
// response sits in the output register while the next request is accepted
// and walked. The extreme key values are ordinary keys. An insert of an
// absent key into a full store returns success=0, full_error=1 and changes
// nothing. No clearing pass is needed after reset: entries are handed out
// from a fill count or the free list, always written before being read.
// ----------------------------------------------------------------------------
module sorted_key_set #(
   parameter int CAPACITY = sks_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sks_pkg::MODE_W-1:0]        req_mode,
   input  logic signed [sks_pkg::KEY_W-1:0]  req_key,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_success,
   output logic                              rsp_full_error
);

   sks_pkg::cmd_type    cmd;
   sks_pkg::status_type status;

   // sequencer: walk, decide, allocate/relink, hand off
   sks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // memories, pointers and output register
   sks_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_mode       (req_mode),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_success    (rsp_success),
      .rsp_full_error (rsp_full_error)
   );

`ifndef ASSERT_OFF
   // an accepted word starts a walk: no second word in the next cycle
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted back to back");

   // a response is never loaded over a word that is still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid || !rsp_stall))
      else $error("response overwritten while stalled");

   // refusal only when both free list and unused entries are exhausted
   a_full_real: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && cmd.rsp_full) |-> (!status.free_avail && !status.fill_avail))
      else $error("insert refused with free entries left");

   // a refused insert never also reports success
   a_full_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(cmd.rsp_full && cmd.rsp_success))
      else $error("success and full_error together");
`endif

endmodule
